// ===== hdl/binomial_bermudan_call_pricer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the binomial Bermudan call pricer
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BINOMIAL_BERMUDAN_CALL_PRICER_UNIT_DEFINES_SVH
`define BINOMIAL_BERMUDAN_CALL_PRICER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define BBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define BBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BBP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define BBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hdl/bbp_pkg.sv =====
// ----------------------------------------------------------------------------
// bbp_pkg
// Shared constants, types and fixed-point helpers of the lattice pricer.
// ----------------------------------------------------------------------------
package bbp_pkg;

	localparam int MAX_EXERCISE_DATES_DEF = 256;
	localparam int MIN_STEPS_DEF          = 200;
	localparam int STEPS_PER_DATE_DEF     = 4;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	// saturated Q30 product and its clip indication
	typedef struct packed {
		logic        clip;
		logic [31:0] val;
	} sat_t;

	// (a*f) >> 30 clipped to 32 bits
	function automatic sat_t sat_q30(input logic [63:0] p);
		sat_t r;
		r.clip = |p[63:62];
		r.val  = r.clip ? 32'hFFFF_FFFF : p[61:30];
		return r;
	endfunction

	// deepest lattice the storage must hold
	function automatic int steps_cap(input int mn, input int spd, input int mx);
		return (mn > spd * mx) ? mn : spd * mx;
	endfunction

endpackage

// ===== hdl/bbp_mul_cell.sv =====
// ----------------------------------------------------------------------------
// bbp_mul_cell
// One registered 32x32 multiply cell of the node-update chain.
// ----------------------------------------------------------------------------
module bbp_mul_cell (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] prod
);

	logic [63:0] prod_q;

	// product register, payload only
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= {32'd0, a} * {32'd0, b};
		end
	end

	assign prod = prod_q;

endmodule

// ===== hdl/bbp_div.sv =====
// ----------------------------------------------------------------------------
// bbp_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bbp_div #(
	parameter int NUMW = 21,
	parameter int DENW = 10
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic            busy,
	output logic            done,
	output logic [NUMW-1:0] quot
);

	localparam int CW = $clog2(NUMW + 1);

	logic [NUMW-1:0] num_q;
	logic [DENW-1:0] den_q;
	logic [DENW-1:0] rem_q;
	logic [CW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DENW:0]   rem_sh;
	logic [DENW:0]   rem_sub;
	logic            ge;

	// trial subtract
	always_comb begin
		rem_sh  = {rem_q, num_q[NUMW-1]};
		ge      = rem_sh >= {1'b0, den_q};
		rem_sub = ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NUMW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// quotient shifts in where the dividend shifts out
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUMW-2:0], ge};
			rem_q <= rem_sub[DENW-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quot = num_q;

endmodule

// ===== hdl/binomial_bermudan_call_pricer_unit.sv =====
// ----------------------------------------------------------------------------
// binomial_bermudan_call_pricer_unit
// Bermudan call pricing by backward induction on a binomial lattice.
// ----------------------------------------------------------------------------
// One option is priced at a time. With N = max(MIN_STEPS, STEPS_PER_DATE*D)
// steps, leaf prices are built by down multiplies of the spot, then by up
// multiplies with a leaf write per node. Each step then streams its nodes
// through the four-cell multiply chain at one node per cycle off the single
// read port of the lattice stores, followed by a drain of the chain. Each
// early exercise date costs one serial division to locate its step. The
// result waits in an output register while the next option is taken.
// ----------------------------------------------------------------------------
module binomial_bermudan_call_pricer_unit
	import bbp_pkg::*;
#(
	parameter int MAX_EXERCISE_DATES = MAX_EXERCISE_DATES_DEF,
	parameter int MIN_STEPS          = MIN_STEPS_DEF,
	parameter int STEPS_PER_DATE     = STEPS_PER_DATE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [31:0] spot,
	input  logic [31:0] strike,
	input  logic [31:0] up_factor,
	input  logic [30:0] down_factor,
	input  logic [30:0] up_prob,
	input  logic [30:0] discount_factor,
	input  logic [8:0]  num_exercise_dates,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] option_price,
	output logic        saturated
);

`include "binomial_bermudan_call_pricer_unit_defines.svh"

	localparam int STEPS_CAP = steps_cap(MIN_STEPS, STEPS_PER_DATE, MAX_EXERCISE_DATES);
	localparam int DEPTH     = STEPS_CAP + 1;
	localparam int AW        = $clog2(DEPTH);
	localparam int NW        = $clog2(STEPS_CAP + 2);
	localparam int DENW      = 10;
	localparam int NUMW      = NW + DENW;

	typedef enum logic [3:0] {
		S_IDLE, S_DOWN, S_DOWN2, S_LEAFW, S_UP1, S_UP2,
		S_EXCHK, S_DIVW, S_RUN, S_DRAIN, S_DONE
	} state_t;

	state_t state_q;

	// option registers
	logic [31:0] strike_q, up_q, x_q;
	logic [30:0] down_q, prob_q, qprob_q, disc_q;
	logic [8:0]  d_q, ex_idx_q;
	logic [NW-1:0] n_q, cnt_q, step_q;
	logic        early_q, clip_q, is_ex_q, t_valid_q;
	logic [NUMW-1:0] t_q;
	logic [31:0] root_q;
	logic        out_valid_q;
	logic [31:0] out_price_q;
	logic        out_sat_q;

	// node pipeline
	logic          v_s1, first_s1, v_s2, v_s3, v_s4;
	logic [AW-1:0] idx_s1, idx_s2, idx_s3, idx_s4;
	logic [31:0]   vval_s1, pval_s1, mean_s3, price_s3, price_s4;
	logic [31:0]   vcur_q;

	// lattice stores
	logic [31:0] vmem [DEPTH];
	logic [31:0] pmem [DEPTH];

	// accept-time decode
	logic [8:0]    dates_cl;
	logic [31:0]   nfull;
	logic [NW-1:0] n_c;
	logic [30:0]   prob_c;

	always_comb begin
		if (int'({23'd0, num_exercise_dates}) > MAX_EXERCISE_DATES) begin
			dates_cl = 9'(MAX_EXERCISE_DATES);
		end else begin
			dates_cl = num_exercise_dates;
		end
		nfull  = 32'(STEPS_PER_DATE) * {23'd0, dates_cl};
		n_c    = (nfull < 32'(MIN_STEPS)) ? NW'(MIN_STEPS) : NW'(nfull);
		prob_c = (up_prob > ONE_Q30) ? ONE_Q30 : up_prob;
	end

	// multiply chain
	logic        c0_en, c1_en, c2_en, c3_en;
	logic [31:0] c2_a, c2_b;
	logic [63:0] c0_p, c1_p, c2_p, c3_p;
	sat_t        c2_sat, c3_sat;

	always_comb begin
		c0_en = v_s1 && !first_s1;
		c1_en = c0_en;
		c3_en = v_s3;
		c2_sat = sat_q30(c2_p);
		c3_sat = sat_q30(c3_p);
		c2_en = 1'b0;
		c2_a  = pval_s1;
		c2_b  = up_q;
		case (state_q)
			S_DOWN: begin
				c2_en = (cnt_q != n_q);
				c2_a  = x_q;
				c2_b  = {1'b0, down_q};
			end
			S_LEAFW: begin
				c2_en = (cnt_q != '0);
				c2_a  = x_q;
			end
			S_UP1: begin
				c2_en = 1'b1;
				c2_a  = c2_sat.val;
			end
			default: begin
				c2_en = c0_en;
			end
		endcase
	end

	bbp_mul_cell u_cell0 (.clk(clk), .en(c0_en), .a({1'b0, prob_q}), .b(vcur_q), .prod(c0_p));
	bbp_mul_cell u_cell1 (.clk(clk), .en(c1_en), .a({1'b0, qprob_q}), .b(vval_s1), .prod(c1_p));
	bbp_mul_cell u_cell2 (.clk(clk), .en(c2_en), .a(c2_a), .b(c2_b), .prod(c2_p));
	bbp_mul_cell u_cell3 (.clk(clk), .en(c3_en), .a(mean_s3), .b({1'b0, disc_q}), .prod(c3_p));

	// exercise step divider
	logic            div_start, div_busy, div_done;
	logic [NUMW-1:0] div_num, div_quot;
	logic [DENW-1:0] div_den;
	logic [NW-1:0]   s_c;

	always_comb begin
		s_c     = step_q - 1'b1;
		div_num = ((NUMW'(ex_idx_q) * NUMW'(n_q)) << 1) + NUMW'(d_q - 9'd1);
		div_den = {d_q - 9'd1, 1'b0};
		div_start = (state_q == S_EXCHK) && (step_q != '0) && early_q
			&& (ex_idx_q != '0) && !t_valid_q;
	end

	bbp_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.busy(div_busy), .done(div_done), .quot(div_quot)
	);

	// node result and store write
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wv, wp, cont, leaf_v;
	logic [63:0]   sum_c;
	logic          clip_set;

	always_comb begin
		sum_c  = c0_p + c1_p;
		leaf_v = (x_q > strike_q) ? (x_q - strike_q) : 32'd0;
		cont   = c3_sat.val;
		if (is_ex_q && (price_s4 > strike_q) && ((price_s4 - strike_q) > c3_sat.val)) begin
			cont = price_s4 - strike_q;
		end
		we    = v_s4 || (state_q == S_LEAFW);
		waddr = v_s4 ? idx_s4 : cnt_q[AW-1:0];
		wv    = v_s4 ? cont : leaf_v;
		wp    = v_s4 ? price_s4 : x_q;
		clip_set = (v_s4 && c3_sat.clip) || (v_s2 && c2_sat.clip)
			|| (((state_q == S_DOWN2) || (state_q == S_UP1) || (state_q == S_UP2))
				&& c2_sat.clip);
	end

	// lattice stores: one write, one registered read
	always_ff @(posedge clk) begin
		if (we) begin
			vmem[waddr] <= wv;
			pmem[waddr] <= wp;
		end
		if (state_q == S_RUN) begin
			vval_s1 <= vmem[cnt_q[AW-1:0]];
			pval_s1 <= pmem[cnt_q[AW-1:0]];
		end
	end

	// pipeline valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_RUN);
			v_s2 <= v_s1 && !first_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		first_s1 <= (cnt_q == '0);
		idx_s1   <= AW'(cnt_q - 1'b1);
		if (v_s1) begin
			vcur_q <= vval_s1;
		end
		idx_s2   <= idx_s1;
		idx_s3   <= idx_s2;
		mean_s3  <= sum_c[61:30];
		price_s3 <= c2_sat.val;
		idx_s4   <= idx_s3;
		price_s4 <= price_s3;
		if (v_s4) begin
			root_q <= cont;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			step_q      <= '0;
			ex_idx_q    <= '0;
			t_valid_q   <= 1'b0;
			is_ex_q     <= 1'b0;
			clip_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// a finished price loading this cycle takes the slot itself
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			if (clip_set) begin
				clip_q <= 1'b1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						strike_q  <= strike;
						up_q      <= up_factor;
						down_q    <= down_factor;
						disc_q    <= discount_factor;
						prob_q    <= prob_c;
						qprob_q   <= ONE_Q30 - prob_c;
						d_q       <= dates_cl;
						n_q       <= n_c;
						step_q    <= n_c;
						early_q   <= (dates_cl >= 9'd3);
						ex_idx_q  <= (dates_cl >= 9'd3) ? (dates_cl - 9'd2) : 9'd0;
						t_valid_q <= 1'b0;
						x_q       <= spot;
						cnt_q     <= '0;
						clip_q    <= 1'b0;
						state_q   <= S_DOWN;
					end
				end
				S_DOWN: begin
					state_q <= (cnt_q == n_q) ? S_LEAFW : S_DOWN2;
				end
				S_DOWN2: begin
					x_q     <= c2_sat.val;
					cnt_q   <= cnt_q + 1'b1;
					state_q <= S_DOWN;
				end
				S_LEAFW: begin
					state_q <= (cnt_q == '0) ? S_EXCHK : S_UP1;
				end
				S_UP1: begin
					state_q <= S_UP2;
				end
				S_UP2: begin
					x_q     <= c2_sat.val;
					cnt_q   <= cnt_q - 1'b1;
					state_q <= S_LEAFW;
				end
				S_EXCHK: begin
					cnt_q <= '0;
					if (step_q == '0) begin
						state_q <= S_DONE;
					end else if (!early_q || (ex_idx_q == '0)) begin
						is_ex_q <= 1'b0;
						state_q <= S_RUN;
					end else if (!t_valid_q) begin
						state_q <= S_DIVW;
					end else if (t_q > NUMW'(s_c)) begin
						ex_idx_q  <= ex_idx_q - 9'd1;
						t_valid_q <= 1'b0;
					end else begin
						is_ex_q <= (t_q == NUMW'(s_c));
						state_q <= S_RUN;
					end
				end
				S_DIVW: begin
					if (div_done) begin
						t_q       <= div_quot;
						t_valid_q <= 1'b1;
						state_q   <= S_EXCHK;
					end
				end
				S_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == step_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (!(v_s1 || v_s2 || v_s3 || v_s4)) begin
						step_q  <= step_q - 1'b1;
						state_q <= S_EXCHK;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_price_q <= root_q;
						out_sat_q   <= clip_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign option_price = out_price_q;
	assign saturated    = out_sat_q;

	// checks
	`BBP_ASSERT_IMPL(a_idle_empty, clk, arst_n, state_q == S_IDLE,
		!(v_s1 || v_s2 || v_s3 || v_s4), "node pipeline busy while idle")
	`BBP_ASSERT_IMPL(a_div_free, clk, arst_n, div_start, !div_busy,
		"divider started while busy")
	`BBP_ASSERT_NEXT(a_done_out, clk, arst_n,
		(state_q == S_DONE) && (!out_valid_q || out_ready), out_valid_q,
		"finished price not presented")

endmodule
